// ----- hw/rtl/brp_pkg.sv -----
// Shared types and constants of the bell row permuter.
package brp_pkg;

   // Field formats of the row words: one nibble per place.
   localparam int BELL_W       = 4;
   localparam int FIELD_PLACES = 16;
   localparam int ROW_W        = BELL_W * FIELD_PLACES;

   // Command codes of the request transaction.
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ROUNDS = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

   // Load status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_OUT_RANGE  = 2'd1;
   localparam logic [1:0] ST_MISSING    = 2'd2;
   localparam logic [1:0] ST_TENOR_BAD  = 2'd3;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_BELLS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TENOR_LAST   = 1'b1;

   // Request payload widths.
   localparam int MASK_W  = 16;
   localparam int SWAP_W  = 4;
   localparam int QUERY_W = 5;
   localparam int COUNT_W = 16;

   // Flags the place step unit hands back to the sequencer.
   typedef struct packed {
      logic [BELL_W-1:0] cur_bell;
      logic              key_match;
      logic              below_n;
      logic              inv_par;
   } step_result_type;

endpackage

// ----- hw/rtl/brp_if.sv -----
// Request and response channel interfaces of the bell row permuter.
interface brp_req_if
   import brp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [MASK_W-1:0]    place_mask;
   logic [SWAP_W-1:0]    swap_place;
   logic [ROW_W-1:0]     load_row;
   logic [QUERY_W-1:0]   query_bell;

   modport source (output valid, cmd, place_mask, swap_place, load_row, query_bell,
                   input ready);
   modport sink   (input valid, cmd, place_mask, swap_place, load_row, query_bell,
                   output ready);
endinterface

interface brp_rsp_if
   import brp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     row_out;
   logic                 in_course;
   logic                 is_rounds;
   logic                 stroke_back;
   logic [COUNT_W-1:0]   row_number;
   logic [BELL_W-1:0]    bell_place;
   logic                 bell_found;
   logic [1:0]           load_status;

   modport source (output valid, row_out, in_course, is_rounds, stroke_back, row_number,
                   bell_place, bell_found, load_status, input ready);
   modport sink   (input valid, row_out, in_course, is_rounds, stroke_back, row_number,
                   bell_place, bell_found, load_status, output ready);
endinterface

// ----- hw/rtl/brp_step_unit.sv -----
// Shared place step unit: looks at one place of a row and its neighbors.
module brp_step_unit
   import brp_pkg::*;
#(
   parameter int  MAX_BELLS = 16,
   localparam int IDX_W     = $clog2(MAX_BELLS),
   localparam int CNT_W     = $clog2(MAX_BELLS + 1)
) (
   input  logic [MAX_BELLS-1:0][BELL_W-1:0] src_i,
   input  logic [IDX_W-1:0]                 place_i,
   input  logic [CNT_W-1:0]                 bells_i,
   input  logic [BELL_W-1:0]                key_i,
   output step_result_type                  result_o,
   output logic [MAX_BELLS-1:0][BELL_W-1:0] swapped_o
);

   logic [BELL_W-1:0] cur_bell;
   logic              inv_par;

   assign cur_bell = src_i[place_i];

   // Parity of the bells after this place that are lower than it.
   always_comb begin
      inv_par = 1'b0;
      for (int j = 0; j < MAX_BELLS; j++) begin
         if (j > int'(place_i) && j < int'(bells_i) && src_i[j] < cur_bell) begin
            inv_par = ~inv_par;
         end
      end
   end

   // Row with this place exchanged with the next one up.
   always_comb begin
      swapped_o = src_i;
      for (int k = 0; k < MAX_BELLS - 1; k++) begin
         if (k == int'(place_i)) begin
            swapped_o[k]     = src_i[k + 1];
            swapped_o[k + 1] = src_i[k];
         end
      end
   end

   assign result_o.cur_bell  = cur_bell;
   assign result_o.key_match = (cur_bell == key_i);
   assign result_o.below_n   = ({1'b0, cur_bell} < (BELL_W + 1)'(bells_i));
   assign result_o.inv_par   = inv_par;

endmodule

// ----- hw/rtl/bell_row_permuter_unit.sv -----
// Top level of the bell row permuter: sequencer, row state and response register.
//
// The block holds a row of N bells, a stroke bit and a row counter. Each request
// transaction on req_bus carries one command (apply change, swap one adjacent
// pair, set rounds, load a row, find a bell) and gives exactly one response
// transaction on rsp_bus with the row, its parity, the rounds flag, stroke,
// counter, search answer and load status. N and the tenor check are set on the
// csr_ port; the user must write them only while no command is in flight, and the
// block itself does not enforce it. Writing N returns the row to rounds. A command
// is taken only while the sequencer is idle. Its work runs one place per cycle
// through the shared place step unit: a change walks up the row, a find scans it,
// a swap exchanges one adjacent pair, and a load runs a validation pass, a check
// step, then a parity pass over the new row; set rounds and unused codes go
// straight to the report. The next command is taken after the report.
// The response waits in an output register; the next command is accepted while
// it waits, but its own report holds until the receiver has taken the previous
// response. Synchronous reset gives rounds, handstroke, counter zero, in course,
// eight bells (fewer if MAX_BELLS is smaller) and no tenor check, and no response pending.
module bell_row_permuter_unit
   import brp_pkg::*;
#(
   parameter int MAX_BELLS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   brp_req_if.sink               req_bus,
   brp_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BELLS);
   localparam int CNT_W = $clog2(MAX_BELLS + 1);
   localparam int RESET_BELLS = (MAX_BELLS < 8) ? MAX_BELLS : 8;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CHANGE = 8'b0000_0010,
      S_SWAP   = 8'b0000_0100,
      S_VALID  = 8'b0000_1000,
      S_CHECK  = 8'b0001_0000,
      S_PARITY = 8'b0010_0000,
      S_FIND   = 8'b0100_0000,
      S_REPORT = 8'b1000_0000
   } state_type;

   typedef logic [MAX_BELLS-1:0][BELL_W-1:0] row_type;

   // Control and row state.
   state_type          state_ff, state_in;
   row_type            row_ff, row_in;
   logic               stroke_ff, stroke_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   logic               parity_ff, parity_in;
   logic [CNT_W-1:0]   bells_ff, bells_in;
   logic               tenor_req_ff, tenor_req_in;
   logic [CNT_W-1:0]   p_ff, p_in;
   logic [MAX_BELLS-1:0] seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Latched request payload and per-command result fields.
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [SWAP_W-1:0]  swp_ff, swp_in;
   logic [FIELD_PLACES-1:0][BELL_W-1:0] ld_ff, ld_in;
   logic [BELL_W-1:0]  key_ff, key_in;
   logic [BELL_W-1:0]  place_ff, place_in;
   logic               found_ff, found_in;
   logic [1:0]         status_ff, status_in;

   // Response register.
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_course_ff, rsp_rounds_ff, rsp_stroke_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [BELL_W-1:0]  rsp_place_ff;
   logic               rsp_found_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_is_rounds;

   // Step unit hookup.
   row_type            unit_src;
   logic [IDX_W-1:0]   unit_place;
   step_result_type    step;
   row_type            swapped;

   logic               req_accept;
   logic               out_load;
   logic [CNT_W:0]     p_plus1;
   logic [CNT_W:0]     bells_wide;
   logic [CNT_W-1:0]   last_place;
   logic [MAX_BELLS-1:0] full_mask;
   logic [MAX_BELLS-1:0] mask_view;
   row_type            ld_view;
   row_type            rounds_row;
   logic [CSR_DATA_W-1:0] bells_clamped;

   assign req_accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_load    = (state_ff == S_REPORT) && (!rsp_valid_ff || rsp_bus.ready);
   assign p_plus1     = (CNT_W + 1)'(p_ff) + (CNT_W + 1)'(1);
   assign bells_wide  = (CNT_W + 1)'(bells_ff);
   assign last_place  = bells_ff - CNT_W'(1);
   assign mask_view   = mask_ff[MAX_BELLS-1:0];
   assign ld_view     = ld_ff[MAX_BELLS-1:0];

   // Rounds row and the mask of bells expected after a full load.
   always_comb begin
      for (int k = 0; k < MAX_BELLS; k++) begin
         rounds_row[k] = BELL_W'(k);
         full_mask[k]  = (k < int'(bells_ff));
      end
   end

   // Bell count written out of range is clamped to the legal span.
   always_comb begin
      if (csr_wdata < CSR_DATA_W'(2)) begin
         bells_clamped = CSR_DATA_W'(2);
      end else if (csr_wdata > CSR_DATA_W'(MAX_BELLS)) begin
         bells_clamped = CSR_DATA_W'(MAX_BELLS);
      end else begin
         bells_clamped = csr_wdata;
      end
   end

   // The step unit reads the load word during validation and the row otherwise.
   assign unit_src   = (state_ff == S_VALID) ? ld_view : row_ff;
   assign unit_place = (state_ff == S_SWAP) ? swp_ff[IDX_W-1:0] : p_ff[IDX_W-1:0];

   brp_step_unit #(
      .MAX_BELLS (MAX_BELLS)
   ) u_step (
      .src_i     (unit_src),
      .place_i   (unit_place),
      .bells_i   (bells_ff),
      .key_i     (key_ff),
      .result_o  (step),
      .swapped_o (swapped)
   );

   // Sequencer and row update.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      stroke_in    = stroke_ff;
      counter_in   = counter_ff;
      parity_in    = parity_ff;
      bells_in     = bells_ff;
      tenor_req_in = tenor_req_ff;
      p_in         = p_ff;
      seen_in      = seen_ff;
      cmd_in       = cmd_ff;
      mask_in      = mask_ff;
      swp_in       = swp_ff;
      ld_in        = ld_ff;
      key_in       = key_ff;
      place_in     = place_ff;
      found_in     = found_ff;
      status_in    = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_bus.cmd;
               mask_in   = req_bus.place_mask;
               swp_in    = req_bus.swap_place;
               ld_in     = req_bus.load_row;
               key_in    = BELL_W'(req_bus.query_bell - QUERY_W'(1));
               place_in  = '0;
               found_in  = 1'b0;
               status_in = ST_OK;
               p_in      = '0;
               seen_in   = '0;
               priority if (req_bus.cmd == CMD_CHANGE) begin
                  state_in = S_CHANGE;
               end else if (req_bus.cmd == CMD_SWAP) begin
                  state_in = S_SWAP;
               end else if (req_bus.cmd == CMD_ROUNDS) begin
                  row_in    = rounds_row;
                  parity_in = 1'b1;
                  state_in  = S_REPORT;
               end else if (req_bus.cmd == CMD_LOAD) begin
                  state_in = S_VALID;
               end else if (req_bus.cmd == CMD_FIND && req_bus.query_bell != '0 &&
                            req_bus.query_bell <= QUERY_W'(bells_ff)) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_REPORT;
               end
            end
         end
         S_CHANGE: begin
            // Walk up the row: a fixed or unpaired place steps one, a swap steps two.
            if (p_ff >= bells_ff) begin
               stroke_in  = ~stroke_ff;
               counter_in = counter_ff + COUNT_W'(1);
               state_in   = S_REPORT;
            end else if (mask_view[p_ff[IDX_W-1:0]] || p_plus1 >= bells_wide) begin
               p_in = p_ff + CNT_W'(1);
            end else begin
               row_in    = swapped;
               parity_in = ~parity_ff;
               p_in      = p_ff + CNT_W'(2);
            end
         end
         S_SWAP: begin
            if ((SWAP_W + 1)'(swp_ff) + (SWAP_W + 1)'(1) < (SWAP_W + 1)'(bells_ff)) begin
               row_in    = swapped;
               parity_in = ~parity_ff;
            end
            state_in = S_REPORT;
         end
         S_VALID: begin
            // One place of the load word per cycle: range check and presence mask.
            if (p_ff >= bells_ff) begin
               state_in = S_CHECK;
            end else if (step.below_n) begin
               seen_in = seen_ff | (MAX_BELLS'(1) << step.cur_bell);
               p_in    = p_ff + CNT_W'(1);
            end else begin
               status_in = ST_OUT_RANGE;
               state_in  = S_REPORT;
            end
         end
         S_CHECK: begin
            if (seen_ff != full_mask) begin
               status_in = ST_MISSING;
               state_in  = S_REPORT;
            end else if (tenor_req_ff &&
                         ld_view[last_place[IDX_W-1:0]] != BELL_W'(last_place)) begin
               status_in = ST_TENOR_BAD;
               state_in  = S_REPORT;
            end else begin
               for (int k = 0; k < MAX_BELLS; k++) begin
                  if (k < int'(bells_ff)) begin
                     row_in[k] = ld_view[k];
                  end
               end
               parity_in = 1'b1;
               p_in      = '0;
               state_in  = S_PARITY;
            end
         end
         S_PARITY: begin
            // Inversion count parity, one place per cycle.
            if (p_ff >= bells_ff) begin
               state_in = S_REPORT;
            end else begin
               parity_in = parity_ff ^ step.inv_par;
               p_in      = p_ff + CNT_W'(1);
            end
         end
         S_FIND: begin
            if (p_ff >= bells_ff) begin
               state_in = S_REPORT;
            end else if (step.key_match) begin
               found_in = 1'b1;
               place_in = BELL_W'(p_ff);
               state_in = S_REPORT;
            end else begin
               p_in = p_ff + CNT_W'(1);
            end
         end
         S_REPORT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The user must make configuration writes only while idle; the block does not enforce it.
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BELLS_IN_USE: begin
               bells_in  = CNT_W'(bells_clamped);
               row_in    = rounds_row;
               parity_in = 1'b1;
            end
            CSR_TENOR_LAST: begin
               tenor_req_in = csr_wdata[0];
            end
            default: begin
               tenor_req_in = tenor_req_ff;
            end
         endcase
      end
   end

   // Report view of the row: places beyond N read as zero.
   always_comb begin
      rsp_row_in    = '0;
      rsp_is_rounds = 1'b1;
      for (int k = 0; k < MAX_BELLS; k++) begin
         if (k < int'(bells_ff)) begin
            rsp_row_in[k*BELL_W +: BELL_W] = row_ff[k];
            if (row_ff[k] != BELL_W'(k)) begin
               rsp_is_rounds = 1'b0;
            end
         end
      end
   end

   // Response valid: set on report, cleared when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= rounds_row;
         stroke_ff    <= 1'b0;
         counter_ff   <= '0;
         parity_ff    <= 1'b1;
         bells_ff     <= CNT_W'(RESET_BELLS);
         tenor_req_ff <= 1'b0;
         p_ff         <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         stroke_ff    <= stroke_in;
         counter_ff   <= counter_in;
         parity_ff    <= parity_in;
         bells_ff     <= bells_in;
         tenor_req_ff <= tenor_req_in;
         p_ff         <= p_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      mask_ff   <= mask_in;
      swp_ff    <= swp_in;
      ld_ff     <= ld_in;
      key_ff    <= key_in;
      place_ff  <= place_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (out_load) begin
         rsp_row_ff    <= rsp_row_in;
         rsp_course_ff <= parity_ff;
         rsp_rounds_ff <= rsp_is_rounds;
         rsp_stroke_ff <= stroke_ff;
         rsp_count_ff  <= counter_ff;
         rsp_place_ff  <= place_ff;
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= (cmd_ff == CMD_LOAD) ? status_ff : ST_OK;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.row_out     = rsp_row_ff;
   assign rsp_bus.in_course   = rsp_course_ff;
   assign rsp_bus.is_rounds   = rsp_rounds_ff;
   assign rsp_bus.stroke_back = rsp_stroke_ff;
   assign rsp_bus.row_number  = rsp_count_ff;
   assign rsp_bus.bell_place  = rsp_place_ff;
   assign rsp_bus.bell_found  = rsp_found_ff;
   assign rsp_bus.load_status = rsp_status_ff;

   // The sequencer takes no second command in the cycle after accepting one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_bus.ready)
      else $error("request accepted while a command was still in work");

   // The row counter only advances at the end of a change.
   a_counter_only_on_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CHANGE) |=> (counter_ff == $past(counter_ff)))
      else $error("row counter moved outside a change");

   // Stroke and counter always move together.
   a_stroke_with_counter: assert property (@(posedge clock) disable iff (reset)
      (stroke_ff != stroke_in) == (counter_ff != counter_in))
      else $error("stroke and row counter out of step");

   // During a change, parity pass or find, the place pointer never runs beyond the bell count.
   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHANGE || state_ff == S_PARITY || state_ff == S_FIND) |->
      (p_ff <= bells_ff))
      else $error("place pointer beyond the row");

   // A report never overwrites a response the receiver has not taken.
   a_no_response_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(rsp_row_ff)))
      else $error("pending response lost or changed");

endmodule
